/* rtl/core/dvm_pkg.sv */
// Package for the direction/velocity modulator.
// Holds config register map, reset values, fixed-point constants and shared types.
// No dependencies.
`timescale 1ns / 1ps

package dvm_pkg;

  localparam int unsigned DATA_W   = 16;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned APB_W    = 32;
  localparam int unsigned DIV_STEPS = 8;   // two quotient bits per step
  localparam int unsigned STEP_W   = 3;

  localparam logic [DATA_W-1:0] FULL_SCALE   = 16'd32768;
  localparam logic [DATA_W-1:0] HALF_TURN    = 16'd32768;
  localparam logic [DATA_W-1:0] QUARTER_TURN = 16'd16384;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_TARGET_DIR  = 3'd0;
  localparam logic [2:0] REG_DIR_TOL     = 3'd1;
  localparam logic [2:0] REG_DIR_TRANS   = 3'd2;
  localparam logic [2:0] REG_SPD_TOL     = 3'd3;
  localparam logic [2:0] REG_SPD_TRANS   = 3'd4;
  localparam logic [2:0] REG_SYMMETRIC   = 3'd5;
  localparam logic [2:0] REG_MODE        = 3'd6;

  // combining modes
  localparam logic [1:0] MODE_HIGH   = 2'd0;
  localparam logic [1:0] MODE_LOW    = 2'd1;
  localparam logic [1:0] MODE_TOGGLE = 2'd2;

  localparam logic [DATA_W-1:0] RST_DIR_TRANS = 16'd8192;
  localparam logic [DATA_W-1:0] RST_SPD_TRANS = 16'd1024;

  typedef struct packed {
    logic [DATA_W-1:0] target_direction;
    logic [DATA_W-1:0] dir_tol;
    logic [DATA_W-1:0] dir_width;
    logic [DATA_W-1:0] speed_tolerance;
    logic [DATA_W-1:0] speed_transition;
    logic              symmetric;
    logic [1:0]        low_speed_mode;
  } cfg_t;

  // controller -> datapath commands
  typedef struct packed {
    logic capture;    // take an input beat
    logic load_spd;   // store deviation, set up speed ramp division
    logic load_dev;   // store speed effect, set up deviation ramp division
    logic step;       // one divider step
    logic store_dev;  // store deviation effect
    logic load_out;   // combine, update flag, fill output register
  } cmd_t;

endpackage

/* rtl/core/dvm_regs.sv */
// Configuration register file of the direction/velocity modulator.
// APB-style write/read decode and the transition clamp; uses dvm_pkg.
`timescale 1ns / 1ps

module dvm_regs
  import dvm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [APB_W-1:0]  pwdata,
  output logic [APB_W-1:0]  prdata,
  output cfg_t              cfg
);

  logic              wr_en;
  logic [2:0]        idx;
  logic [DATA_W-1:0] v16;
  logic [DATA_W:0]   bound;
  logic [DATA_W-1:0] trans_clamped;

  assign wr_en = psel && penable && pwrite;
  assign idx   = paddr[ADDR_W-1:2];
  assign v16   = pwdata[DATA_W-1:0];

  // transition may not exceed half turn minus the tolerance held now
  always_comb begin
    if (cfg.dir_tol >= HALF_TURN) begin
      bound = '0;
    end else begin
      bound = {1'b0, HALF_TURN} - {1'b0, cfg.dir_tol};
    end
    if ({1'b0, v16} < bound) begin
      trans_clamped = v16;
    end else begin
      trans_clamped = bound[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_direction     <= '0;
      cfg.dir_tol              <= '0;
      cfg.dir_width            <= RST_DIR_TRANS;
      cfg.speed_tolerance      <= '0;
      cfg.speed_transition     <= RST_SPD_TRANS;
      cfg.symmetric            <= 1'b0;
      cfg.low_speed_mode       <= MODE_HIGH;
    end else if (wr_en) begin
      unique case (idx)
        REG_TARGET_DIR: cfg.target_direction     <= v16;
        REG_DIR_TOL:    cfg.dir_tol              <= v16;
        REG_DIR_TRANS:  cfg.dir_width            <= trans_clamped;
        REG_SPD_TOL:    cfg.speed_tolerance      <= v16;
        REG_SPD_TRANS:  cfg.speed_transition     <= v16;
        REG_SYMMETRIC:  cfg.symmetric            <= pwdata[0];
        REG_MODE:       cfg.low_speed_mode       <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_TARGET_DIR: prdata[DATA_W-1:0] = cfg.target_direction;
      REG_DIR_TOL:    prdata[DATA_W-1:0] = cfg.dir_tol;
      REG_DIR_TRANS:  prdata[DATA_W-1:0] = cfg.dir_width;
      REG_SPD_TOL:    prdata[DATA_W-1:0] = cfg.speed_tolerance;
      REG_SPD_TRANS:  prdata[DATA_W-1:0] = cfg.speed_transition;
      REG_SYMMETRIC:  prdata[0]          = cfg.symmetric;
      REG_MODE:       prdata[1:0]        = cfg.low_speed_mode;
      default:        prdata             = '0;
    endcase
  end

endmodule

/* rtl/core/dvm_ctrl.sv */
// Sequencing controller of the direction/velocity modulator.
// Runs the two ramp divisions on the shared divider and owns the handshakes; uses dvm_pkg.
`timescale 1ns / 1ps

module dvm_ctrl
  import dvm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PREP   = 3'd1;
  localparam logic [2:0] S_SDIV   = 3'd2;
  localparam logic [2:0] S_DLOAD  = 3'd3;
  localparam logic [2:0] S_DDIV   = 3'd4;
  localparam logic [2:0] S_DSTORE = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0]        state, state_next;
  logic [STEP_W-1:0] step_cnt, step_cnt_next;
  logic              slot_free;
  logic              last_step;

  assign in_stall  = rst || (state != S_IDLE);
  assign slot_free = !out_valid || !out_stall;
  assign last_step = (step_cnt == STEP_W'(DIV_STEPS - 1));

  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    cmd           = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_PREP;
        end
      end
      S_PREP: begin
        cmd.load_spd  = 1'b1;
        step_cnt_next = '0;
        state_next    = S_SDIV;
      end
      S_SDIV: begin
        cmd.step      = 1'b1;
        step_cnt_next = step_cnt + 1'b1;
        if (last_step) state_next = S_DLOAD;
      end
      S_DLOAD: begin
        cmd.load_dev  = 1'b1;
        step_cnt_next = '0;
        state_next    = S_DDIV;
      end
      S_DDIV: begin
        cmd.step      = 1'b1;
        step_cnt_next = step_cnt + 1'b1;
        if (last_step) state_next = S_DSTORE;
      end
      S_DSTORE: begin
        cmd.store_dev = 1'b1;
        state_next    = S_OUT;
      end
      S_OUT: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/core/dvm_datapath.sv */
// Datapath of the direction/velocity modulator: deviation, ramp pre-checks,
// shared radix-4 restoring divider, mode combine, hysteresis flag, output register. Uses dvm_pkg.
`timescale 1ns / 1ps

module dvm_datapath
  import dvm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  cmd_t              cmd,
  input  logic [DATA_W-1:0] move_direction,
  input  logic [DATA_W-1:0] move_speed,
  input  logic              update_allowed,
  output logic [DATA_W-1:0] level,
  output logic              toggle_is_high
);

  logic [DATA_W-1:0] dir_q, spd_q;
  logic              upd_q;
  logic [DATA_W-1:0] dev_q;
  logic [DATA_W-1:0] mag_eff, dev_eff;
  logic              flag;

  // divider state
  logic [DATA_W-1:0] rem, quot, divisor;
  logic              is_full, is_zero;

  // deviation, wrapped to half turn and optionally folded
  logic [DATA_W-1:0] diff, dev_wrap, dev_fold;

  always_comb begin
    diff = dir_q - cfg.target_direction;
    if (diff <= HALF_TURN) begin
      dev_wrap = diff;
    end else begin
      dev_wrap = DATA_W'(0) - diff;
    end
    if (cfg.symmetric && (dev_wrap > QUARTER_TURN)) begin
      dev_fold = HALF_TURN - dev_wrap;
    end else begin
      dev_fold = dev_wrap;
    end
  end

  // ramp set-up for whichever operand is being loaded
  logic [DATA_W-1:0] rx, rt, rw, rd;
  logic              r_le, r_ge;

  always_comb begin
    if (cmd.load_dev) begin
      rx = dev_q;
      rt = cfg.dir_tol;
      rw = cfg.dir_width;
    end else begin
      rx = spd_q;
      rt = cfg.speed_tolerance;
      rw = cfg.speed_transition;
    end
    r_le = (rx <= rt);
    rd   = rx - rt;
    r_ge = (rd >= rw);
  end

  // two restoring steps per cycle; remainder stays below divisor
  logic [DATA_W:0]   t1, t2;
  logic [DATA_W-1:0] r1, r2;
  logic              q1, q2;

  always_comb begin
    t1 = {rem, 1'b0};
    q1 = (t1 >= {1'b0, divisor});
    r1 = q1 ? DATA_W'(t1 - {1'b0, divisor}) : t1[DATA_W-1:0];
    t2 = {r1, 1'b0};
    q2 = (t2 >= {1'b0, divisor});
    r2 = q2 ? DATA_W'(t2 - {1'b0, divisor}) : t2[DATA_W-1:0];
  end

  // quot holds floor(d * 65536 / W); effect uses floor(d * 32768 / W)
  logic [DATA_W-1:0] eff;
  always_comb begin
    if (is_full) begin
      eff = FULL_SCALE;
    end else if (is_zero) begin
      eff = '0;
    end else begin
      eff = FULL_SCALE - {1'b0, quot[DATA_W-1:1]};
    end
  end

  // mode combine and flag update
  logic [DATA_W-1:0] inv, lvl;
  logic              flag_next;

  always_comb begin
    inv = FULL_SCALE - mag_eff;
    case (cfg.low_speed_mode)
      MODE_HIGH: lvl = (mag_eff > dev_eff) ? mag_eff : dev_eff;
      MODE_LOW:  lvl = (dev_eff < inv) ? dev_eff : inv;
      MODE_TOGGLE: begin
        if (flag) begin
          lvl = (mag_eff > dev_eff) ? mag_eff : dev_eff;
        end else begin
          lvl = (dev_eff < inv) ? dev_eff : inv;
        end
      end
      default: lvl = FULL_SCALE;
    endcase
    flag_next = flag;
    if (upd_q) begin
      if (flag && (lvl == '0)) begin
        flag_next = 1'b0;
      end else if (!flag && (lvl == FULL_SCALE)) begin
        flag_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flag <= 1'b1;
    end else if (cmd.load_out) begin
      flag <= flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      dir_q <= move_direction;
      spd_q <= move_speed;
      upd_q <= update_allowed;
    end
    if (cmd.load_spd) begin
      dev_q <= dev_fold;
    end
    if (cmd.load_dev) begin
      mag_eff <= eff;
    end
    if (cmd.store_dev) begin
      dev_eff <= eff;
    end
    if (cmd.load_spd || cmd.load_dev) begin
      is_full <= r_le;
      is_zero <= r_ge;
      rem     <= rd;
      divisor <= rw;
      quot    <= '0;
    end else if (cmd.step) begin
      rem  <= r2;
      quot <= {quot[DATA_W-3:0], q1, q2};
    end
    if (cmd.load_out) begin
      level          <= lvl;
      toggle_is_high <= flag_next;
    end
  end

endmodule

/* rtl/core/direction_velocity_modulator.sv */
// Top level of the direction/velocity modulator.
// Instantiates dvm_regs, dvm_ctrl and dvm_datapath; uses dvm_pkg.
`timescale 1ns / 1ps

// One motion sample in, one Q1.15 level out (32768 = 1.0). The direction
// deviation from target_direction is wrapped to a half turn (and folded about
// a quarter turn when symmetric is set), then run through a clamped linear
// ramp; speed goes through its own ramp. Both ramps share one restoring
// divider that resolves two quotient bits per cycle. An item runs from its
// input beat through capture, deviation, 8 speed-ramp steps, reload, 8
// deviation-ramp steps, store and combine before the next input beat is
// taken. Results sit in an output register; the next input beat is taken
// while a finished result still waits, but the block cannot retire a
// result until the previous one has left. Writes to the direction ramp
// width are clamped against the direction tolerance held at that time.
// Config is to be written only while the block is idle.

module direction_velocity_modulator
  import dvm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // input samples
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [DATA_W-1:0] move_direction,
  input  logic [DATA_W-1:0] move_speed,
  input  logic              update_allowed,
  // results
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] level,
  output logic              toggle_is_high,
  // config port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [APB_W-1:0]  pwdata,
  output logic [APB_W-1:0]  prdata,
  output logic              pready
);

  cfg_t cfg;
  cmd_t cmd;

  // zero-wait-state register access
  assign pready = 1'b1;

  dvm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // sequencer: handshakes and divider step count
  dvm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // arithmetic, hysteresis flag and result register
  dvm_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .cmd            (cmd),
    .move_direction (move_direction),
    .move_speed     (move_speed),
    .update_allowed (update_allowed),
    .level          (level),
    .toggle_is_high (toggle_is_high)
  );

endmodule

/* rtl/core/dvm_checker.sv */
// Port-level checker for the direction/velocity modulator, bound to the top level.
// Uses dvm_pkg constants.
`timescale 1ns / 1ps

module dvm_checker
  import dvm_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [DATA_W-1:0] level,
  input logic              toggle_is_high
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(level) && $stable(toggle_is_high))
    else $error("result beat changed while stalled");

  // a valid level never exceeds full scale
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (level <= FULL_SCALE))
    else $error("level above full scale");

  // busy right after an input beat is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again without processing");

  // a fresh result appears only as the block goes idle
  a_ready_with_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_stall)
    else $error("result shown while still busy");

endmodule

bind direction_velocity_modulator dvm_checker u_dvm_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .level          (level),
  .toggle_is_high (toggle_is_high)
);
